[hw/rtl/aavr_pkg.sv]
// Shared types and constants for the axis-angle vector rotation unit.
// No dependencies; imported by every module of the block.
package aavr_pkg;

    localparam int COMPONENT_WIDTH  = 16;
    localparam int FRAC_BITS        = COMPONENT_WIDTH - 2;
    localparam int ANGLE_WIDTH      = 16;
    localparam int SINE_TABLE_DEPTH = 1024;

    // one full turn and one quarter turn in 1/64 degree
    localparam int TURN    = 23040;
    localparam int QUARTER = 5760;
    localparam int PHASE_W = 15;

    // quarter-wave sine table entries, Q2.15, 0..32768
    localparam int SIN_W   = 17;
    localparam int SIN_ONE = 32768;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // reciprocal of QUARTER for the table index division
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_MULT  = (1 << RECIP_SHIFT) / QUARTER;

    typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;
    typedef logic signed [COMPONENT_WIDTH:0]   mid_t;

    typedef struct packed {
        comp_t                         axis_x;
        comp_t                         axis_y;
        comp_t                         axis_z;
        comp_t                         vec_x;
        comp_t                         vec_y;
        comp_t                         vec_z;
        logic signed [ANGLE_WIDTH-1:0] angle_deg;
    } in_t;

    typedef struct packed {
        comp_t rot_x;
        comp_t rot_y;
        comp_t rot_z;
    } out_t;

    // quadrant signs of the sine and cosine lookups
    typedef struct packed {
        logic neg_sin;
        logic neg_cos;
    } sine_sign_t;

endpackage

[hw/rtl/aavr_sine_rom.sv]
// Quarter-wave sine ROM, two registered read ports.
// Contents built at elaboration; depends on aavr_pkg.
module aavr_sine_rom #(
    parameter int SINE_TABLE_DEPTH = aavr_pkg::SINE_TABLE_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] addr_a,
    input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] addr_b,
    output logic [aavr_pkg::SIN_W-1:0]            data_a,
    output logic [aavr_pkg::SIN_W-1:0]            data_b
);
    import aavr_pkg::*;

    typedef logic [SIN_W-1:0] rom_t [SINE_TABLE_DEPTH+1];

    // truncated eight-term Taylor series on a Q30 argument
    function automatic rom_t build_rom();
        rom_t        t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] rnd;
        longint      sum;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            x    = 64'(i) * HALF_PI_Q30 / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 7; n++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            rnd = (64'(sum) + 64'd16384) >> 15;
            if (rnd > 64'(SIN_ONE))
                rnd = 64'(SIN_ONE);
            t[i] = SIN_W'(rnd);
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [SIN_W-1:0] data_a_reg;
    logic [SIN_W-1:0] data_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a_reg <= SINE_ROM[addr_a];
            data_b_reg <= SINE_ROM[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

[hw/rtl/aavr_phase_gen.sv]
// Angle reduction and sine/cosine table addressing, four register stages.
// Depends on aavr_pkg.
module aavr_phase_gen #(
    parameter int SINE_TABLE_DEPTH = aavr_pkg::SINE_TABLE_DEPTH
) (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic signed [aavr_pkg::ANGLE_WIDTH-1:0] angle,
    output logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]   idx_sin,
    output logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]   idx_cos,
    output aavr_pkg::sine_sign_t                    sign
);
    import aavr_pkg::*;

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int R_W    = $clog2(QUARTER);
    localparam int NUM_W  = $clog2(QUARTER * SINE_TABLE_DEPTH + QUARTER / 2 + 1);
    localparam int PROD_W = NUM_W + $clog2(RECIP_MULT + 1);
    localparam int AW     = ANGLE_WIDTH + 1;

    localparam logic signed [AW-1:0] TURN_A  = AW'(TURN);
    localparam logic [PHASE_W:0]     TURN_P  = (PHASE_W + 1)'(TURN);
    localparam logic [PHASE_W:0]     QUART_P = (PHASE_W + 1)'(QUARTER);

    // stage 1: phase in [0, TURN) for sine (0) and cosine (1)
    logic [PHASE_W-1:0] ph_reg [2];
    // stage 2
    logic [NUM_W-1:0]   num2_reg [2];
    logic [1:0]         q2_reg   [2];
    // stage 3
    logic [NUM_W-1:0]   num3_reg [2];
    logic [1:0]         q3_reg   [2];
    logic [IDX_W-1:0]   qe_reg   [2];
    // stage 4
    logic [IDX_W-1:0]   idx_reg  [2];
    logic               neg_reg  [2];

    logic signed [AW-1:0] a_ext;
    logic signed [AW-1:0] a_wrap;
    logic [PHASE_W:0]     pc_sum;
    logic [PHASE_W-1:0]   ph_next [2];

    always_comb
    begin
        a_ext = AW'(angle);
        if (a_ext < 0)
        begin
            a_wrap = a_ext + TURN_A;
            if (a_wrap < 0)
                a_wrap = a_wrap + TURN_A;
        end
        else if (a_ext >= TURN_A)
            a_wrap = a_ext - TURN_A;
        else
            a_wrap = a_ext;
        ph_next[0] = a_wrap[PHASE_W-1:0];
        pc_sum = {1'b0, ph_next[0]} + QUART_P;
        if (pc_sum >= TURN_P)
            ph_next[1] = PHASE_W'(pc_sum - TURN_P);
        else
            ph_next[1] = pc_sum[PHASE_W-1:0];
    end

    logic [R_W-1:0]      r_next   [2];
    logic [1:0]          q_next   [2];
    logic [NUM_W-1:0]    num_next [2];
    logic [PROD_W-1:0]   prod     [2];
    logic [NUM_W-1:0]    back     [2];
    logic [NUM_W-1:0]    rem      [2];
    logic [IDX_W-1:0]    idx_next [2];

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            // quadrant and offset within it
            if (ph_reg[k] < PHASE_W'(QUARTER))
            begin
                q_next[k] = 2'd0;
                r_next[k] = R_W'(ph_reg[k]);
            end
            else if (ph_reg[k] < PHASE_W'(2 * QUARTER))
            begin
                q_next[k] = 2'd1;
                r_next[k] = R_W'(ph_reg[k] - PHASE_W'(QUARTER));
            end
            else if (ph_reg[k] < PHASE_W'(3 * QUARTER))
            begin
                q_next[k] = 2'd2;
                r_next[k] = R_W'(ph_reg[k] - PHASE_W'(2 * QUARTER));
            end
            else
            begin
                q_next[k] = 2'd3;
                r_next[k] = R_W'(ph_reg[k] - PHASE_W'(3 * QUARTER));
            end
            num_next[k] = NUM_W'(r_next[k]) * NUM_W'(SINE_TABLE_DEPTH)
                          + NUM_W'(QUARTER / 2);

            // quotient estimate, low by at most one
            prod[k] = PROD_W'(num2_reg[k]) * PROD_W'(RECIP_MULT);

            // correction and mirror for odd quadrants
            back[k] = NUM_W'(qe_reg[k]) * NUM_W'(QUARTER);
            rem[k]  = num3_reg[k] - back[k];
            if (rem[k] >= NUM_W'(QUARTER))
                idx_next[k] = qe_reg[k] + IDX_W'(1);
            else
                idx_next[k] = qe_reg[k];
            if (q3_reg[k][0])
                idx_next[k] = IDX_W'(SINE_TABLE_DEPTH) - idx_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 2; k++)
            begin
                ph_reg[k]   <= ph_next[k];
                num2_reg[k] <= num_next[k];
                q2_reg[k]   <= q_next[k];
                num3_reg[k] <= num2_reg[k];
                q3_reg[k]   <= q2_reg[k];
                qe_reg[k]   <= IDX_W'(prod[k] >> RECIP_SHIFT);
                idx_reg[k]  <= idx_next[k];
                neg_reg[k]  <= q3_reg[k][1];
            end
        end
    end

    assign idx_sin      = idx_reg[0];
    assign idx_cos      = idx_reg[1];
    assign sign.neg_sin = neg_reg[0];
    assign sign.neg_cos = neg_reg[1];

endmodule

[hw/rtl/aavr_vec_core.sv]
// Dot product, squared norm, cross product and a(a.v) - v|a|^2, four register stages.
// Depends on aavr_pkg.
module aavr_vec_core (
    input  logic           clk,
    input  logic           en,
    input  aavr_pkg::in_t  in_data,
    output aavr_pkg::mid_t cr [3],
    output aavr_pkg::mid_t dc [3],
    output aavr_pkg::comp_t vec [3]
);
    import aavr_pkg::*;

    localparam int CW = COMPONENT_WIDTH;
    localparam int PW = 2 * CW + 1;
    localparam int WW = CW + 5;

    localparam logic signed [WW-1:0] MID_MAX = WW'((64'd1 << CW) - 64'd1);

    // round a Q.2F product to Q.F: add half, floor
    function automatic logic signed [WW-1:0] rnd_q(input logic signed [PW-1:0] p);
        logic signed [PW:0] t;
        t = PW'(p) + ((PW + 1)'(1) << (FRAC_BITS - 1));
        return WW'(t >>> FRAC_BITS);
    endfunction

    function automatic mid_t sat_mid(input logic signed [WW-1:0] x);
        mid_t r;
        if (x > MID_MAX)
            r = mid_t'(MID_MAX);
        else if (x < -MID_MAX)
            r = mid_t'(-MID_MAX);
        else
            r = x[CW:0];
        return r;
    endfunction

    comp_t a_in [3];
    comp_t v_in [3];

    assign a_in[0] = in_data.axis_x;
    assign a_in[1] = in_data.axis_y;
    assign a_in[2] = in_data.axis_z;
    assign v_in[0] = in_data.vec_x;
    assign v_in[1] = in_data.vec_y;
    assign v_in[2] = in_data.vec_z;

    // stage 1: raw products
    logic signed [2*CW-1:0] pr_reg [12];
    comp_t a1_reg [3];
    comp_t v1_reg [3];
    // stage 2
    mid_t  d2_reg;
    mid_t  nn2_reg;
    mid_t  cr2_reg [3];
    comp_t a2_reg [3];
    comp_t v2_reg [3];
    // stage 3
    logic signed [PW-1:0] ad_reg [3];
    logic signed [PW-1:0] vn_reg [3];
    mid_t  cr3_reg [3];
    comp_t v3_reg [3];
    // stage 4
    mid_t  dc4_reg [3];
    mid_t  cr4_reg [3];
    comp_t v4_reg [3];

    logic signed [2*CW-1:0] pr_next [12];
    logic signed [WW-1:0]   rq [12];
    mid_t                   d_next;
    mid_t                   nn_next;
    mid_t                   cr_next [3];
    mid_t                   dc_next [3];

    always_comb
    begin
        pr_next[0]  = a_in[0] * v_in[0];
        pr_next[1]  = a_in[1] * v_in[1];
        pr_next[2]  = a_in[2] * v_in[2];
        pr_next[3]  = a_in[0] * a_in[0];
        pr_next[4]  = a_in[1] * a_in[1];
        pr_next[5]  = a_in[2] * a_in[2];
        pr_next[6]  = a_in[1] * v_in[2];
        pr_next[7]  = a_in[2] * v_in[1];
        pr_next[8]  = a_in[2] * v_in[0];
        pr_next[9]  = a_in[0] * v_in[2];
        pr_next[10] = a_in[0] * v_in[1];
        pr_next[11] = a_in[1] * v_in[0];

        for (int i = 0; i < 12; i++)
            rq[i] = rnd_q(PW'(pr_reg[i]));
        d_next     = sat_mid(rq[0] + rq[1] + rq[2]);
        nn_next    = sat_mid(rq[3] + rq[4] + rq[5]);
        cr_next[0] = sat_mid(rq[6] - rq[7]);
        cr_next[1] = sat_mid(rq[8] - rq[9]);
        cr_next[2] = sat_mid(rq[10] - rq[11]);

        for (int j = 0; j < 3; j++)
            dc_next[j] = sat_mid(rnd_q(ad_reg[j]) - rnd_q(vn_reg[j]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 12; i++)
                pr_reg[i] <= pr_next[i];
            d2_reg  <= d_next;
            nn2_reg <= nn_next;
            for (int j = 0; j < 3; j++)
            begin
                a1_reg[j]  <= a_in[j];
                v1_reg[j]  <= v_in[j];
                a2_reg[j]  <= a1_reg[j];
                v2_reg[j]  <= v1_reg[j];
                cr2_reg[j] <= cr_next[j];
                ad_reg[j]  <= a2_reg[j] * d2_reg;
                vn_reg[j]  <= v2_reg[j] * nn2_reg;
                cr3_reg[j] <= cr2_reg[j];
                v3_reg[j]  <= v2_reg[j];
                dc4_reg[j] <= dc_next[j];
                cr4_reg[j] <= cr3_reg[j];
                v4_reg[j]  <= v3_reg[j];
            end
        end
    end

    assign cr  = cr4_reg;
    assign dc  = dc4_reg;
    assign vec = v4_reg;

endmodule

[hw/rtl/axis_angle_vector_rotation_unit.sv]
// Top level of the axis-angle vector rotation unit (Rodrigues' formula).
// Depends on aavr_pkg, aavr_phase_gen, aavr_sine_rom and aavr_vec_core.

// Rotates vec about axis by angle_deg (1/64 degree, right-handed) and returns
// v + sin*(a x v) + (1 - cos)*(a(a.v) - v|a|^2), all in signed Q2.14 with
// saturation. The block is a seven-stage pipeline: one transaction enters
// every clock while the pipeline is not held. All stages advance
// together; when out_valid is high and out_ready low the whole pipeline
// holds, and in_ready drops in the same cycle, so no transaction is lost or
// repeated. Stages 1-4 reduce the angle and form the sine/cosine table
// addresses (divide by a quarter turn via a reciprocal multiply) in parallel
// with the vector products; stage 5 is the registered read of the
// quarter-wave sine ROM (SINE_TABLE_DEPTH+1 entries, built at elaboration,
// no clearing pass); stages 6 and 7 do the final multiplies, rounding and
// saturation. The block holds no state between transactions.
module axis_angle_vector_rotation_unit #(
    parameter int SINE_TABLE_DEPTH = aavr_pkg::SINE_TABLE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  aavr_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output aavr_pkg::out_t out_data
);
    import aavr_pkg::*;

    localparam int CW    = COMPONENT_WIDTH;
    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int KW    = SIN_W + 1;
    localparam int MW    = KW + CW + 1;
    localparam int SW    = MW + 2;
    localparam int RW    = CW + 7;

    localparam logic signed [RW-1:0] OUT_MAX = RW'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic signed [RW-1:0] OUT_MIN = -OUT_MAX - RW'(1);

    // valid bit per stage, index 0 is stage 1
    logic [6:0] vld_reg;
    logic       adv;

    assign adv       = ~vld_reg[6] | out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[5:0], in_valid};
    end

    // stages 1-4: table addresses
    logic [IDX_W-1:0] idx_sin;
    logic [IDX_W-1:0] idx_cos;
    sine_sign_t       sign4;

    aavr_phase_gen #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_phase (
        .clk     (clk),
        .en      (adv),
        .angle   (in_data.angle_deg),
        .idx_sin (idx_sin),
        .idx_cos (idx_cos),
        .sign    (sign4)
    );

    // stages 1-4: vector terms
    mid_t  cr4 [3];
    mid_t  dc4 [3];
    comp_t v4  [3];

    aavr_vec_core u_vec (
        .clk     (clk),
        .en      (adv),
        .in_data (in_data),
        .cr      (cr4),
        .dc      (dc4),
        .vec     (v4)
    );

    // stage 5: ROM read, vector terms delayed alongside
    logic [SIN_W-1:0] sin_mag;
    logic [SIN_W-1:0] cos_mag;

    aavr_sine_rom #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_rom (
        .clk    (clk),
        .en     (adv),
        .addr_a (idx_sin),
        .addr_b (idx_cos),
        .data_a (sin_mag),
        .data_b (cos_mag)
    );

    sine_sign_t sign5_reg;
    mid_t       cr5_reg [3];
    mid_t       dc5_reg [3];
    comp_t      v5_reg  [3];

    // stage 6: weighted terms
    logic signed [MW-1:0] ps_reg [3];
    logic signed [MW-1:0] pk_reg [3];
    comp_t                v6_reg [3];

    // stage 7: output register
    out_t out_reg;

    logic signed [KW-1:0] s_val;
    logic signed [KW-1:0] c_val;
    logic signed [KW-1:0] k_val;
    logic signed [SW-1:0] sum  [3];
    logic signed [RW-1:0] rsum [3];
    comp_t                r_sat [3];

    always_comb
    begin
        s_val = sign5_reg.neg_sin ? -KW'(sin_mag) : KW'(sin_mag);
        c_val = sign5_reg.neg_cos ? -KW'(cos_mag) : KW'(cos_mag);
        k_val = KW'(SIN_ONE) - c_val;

        for (int j = 0; j < 3; j++)
        begin
            // round the Q.29 sum to Q.14: add half, floor
            sum[j]  = SW'(ps_reg[j]) + SW'(pk_reg[j]) + (SW'(1) << 14);
            rsum[j] = RW'(sum[j] >>> 15) + RW'(v6_reg[j]);
            if (rsum[j] > OUT_MAX)
                r_sat[j] = comp_t'(OUT_MAX);
            else if (rsum[j] < OUT_MIN)
                r_sat[j] = comp_t'(OUT_MIN);
            else
                r_sat[j] = rsum[j][CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sign5_reg <= sign4;
            for (int j = 0; j < 3; j++)
            begin
                cr5_reg[j] <= cr4[j];
                dc5_reg[j] <= dc4[j];
                v5_reg[j]  <= v4[j];
                ps_reg[j]  <= s_val * cr5_reg[j];
                pk_reg[j]  <= k_val * dc5_reg[j];
                v6_reg[j]  <= v5_reg[j];
            end
            out_reg.rot_x <= r_sat[0];
            out_reg.rot_y <= r_sat[1];
            out_reg.rot_z <= r_sat[2];
        end
    end

    assign out_data = out_reg;

    // a stall freezes every stage's valid bit
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
    else $error("pipeline valid bits moved during a stall");

    // an accepted transaction lands in stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
    else $error("accepted transaction not captured");

    // table addresses stay within the quarter-wave table
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> (idx_sin <= IDX_W'(SINE_TABLE_DEPTH))
                    && (idx_cos <= IDX_W'(SINE_TABLE_DEPTH)))
    else $error("sine table address out of range");

    // 1 - cos lies in [0, 2] in Q3.15
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> (k_val >= 0) && (k_val <= KW'(2 * SIN_ONE)))
    else $error("versine factor out of range");

endmodule

[dv/axis_angle_vector_rotation_unit_tb.sv]
// Testbench for the axis-angle vector rotation unit: random and directed
// rotations checked against an in-bench fixed-point Rodrigues predictor.
// Depends on aavr_pkg and the axis_angle_vector_rotation_unit RTL.
`timescale 1ns / 1ps

module axis_angle_vector_rotation_unit_tb;
    import aavr_pkg::*;

    localparam int NUM_RANDOM = 1100;
    localparam int DRAIN_CYCLES = 20;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    axis_angle_vector_rotation_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Stimulus waiting to be driven, and rotations predicted for accepted
    // transactions, oldest first.
    in_t  pending_rotations[$];
    out_t expected_rotations[$];
    int   error_count;
    bit   stimulus_done;

    // ---------------------------------------------------------------------
    // Fixed-point predictor
    // ---------------------------------------------------------------------

    // floor((x + 2^(n-1)) / 2^n); >>> on longint is an arithmetic floor shift
    function automatic longint round_shr(longint x, int n);
        return (x + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // intermediates saturate symmetrically in Q3.F
    function automatic longint clip_mid(longint x);
        longint m;
        m = (longint'(1) <<< COMPONENT_WIDTH) - 1;
        return clip(x, -m, m);
    endfunction

    function automatic longint qmul(longint x, longint y);
        return round_shr(x * y, FRAC_BITS);
    endfunction

    // Quarter-wave table entry by truncated Taylor series on a Q30 argument.
    function automatic longint sine_entry(longint unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint sum;
        x = i * HALF_PI_Q30 / longint'(SINE_TABLE_DEPTH);
        x2 = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        sum = longint'(x);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum -= longint'(term);
            else
                sum += longint'(term);
        end
        if (sum < 0)
            sum = 0;
        return clip((sum + 16384) >>> 15, 0, SIN_ONE);
    endfunction

    // Q2.15 sine of a phase in [0, TURN)
    function automatic longint sine_of_phase(longint p);
        longint q;
        longint r;
        longint idx;
        q = p / QUARTER;
        r = p % QUARTER;
        idx = (r * SINE_TABLE_DEPTH + QUARTER / 2) / QUARTER;
        if (idx > SINE_TABLE_DEPTH)
            idx = SINE_TABLE_DEPTH;
        if (q % 2 == 1)
            idx = SINE_TABLE_DEPTH - idx;
        return (q >= 2) ? -sine_entry(idx) : sine_entry(idx);
    endfunction

    function automatic out_t rotate_vector(in_t t);
        longint a[3];
        longint v[3];
        longint cr[3];
        longint dc[3];
        longint p;
        longint s;
        longint k;
        longint d;
        longint nn;
        longint r;
        longint lo;
        longint hi;
        comp_t  res[3];
        out_t   o;
        a[0] = t.axis_x; a[1] = t.axis_y; a[2] = t.axis_z;
        v[0] = t.vec_x;  v[1] = t.vec_y;  v[2] = t.vec_z;
        p = ((longint'(t.angle_deg) % TURN) + TURN) % TURN;
        s = sine_of_phase(p);
        k = SIN_ONE - sine_of_phase((p + QUARTER) % TURN);
        d  = clip_mid(qmul(a[0], v[0]) + qmul(a[1], v[1]) + qmul(a[2], v[2]));
        nn = clip_mid(qmul(a[0], a[0]) + qmul(a[1], a[1]) + qmul(a[2], a[2]));
        cr[0] = clip_mid(qmul(a[1], v[2]) - qmul(a[2], v[1]));
        cr[1] = clip_mid(qmul(a[2], v[0]) - qmul(a[0], v[2]));
        cr[2] = clip_mid(qmul(a[0], v[1]) - qmul(a[1], v[0]));
        lo = -(longint'(1) <<< (COMPONENT_WIDTH - 1));
        hi = -lo - 1;
        for (int j = 0; j < 3; j++) begin
            dc[j] = clip_mid(qmul(a[j], d) - qmul(v[j], nn));
            r = v[j] + round_shr(s * cr[j] + k * dc[j], 15);
            res[j] = comp_t'(clip(r, lo, hi));
        end
        o.rot_x = res[0];
        o.rot_y = res[1];
        o.rot_z = res[2];
        return o;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------------

    function automatic comp_t rand_comp();
        case ($urandom_range(0, 9))
            0: return comp_t'(16'sh8000);
            1: return comp_t'(16'sh7fff);
            2: return comp_t'(16'sh4000);
            3: return comp_t'(16'shc000);
            4: return comp_t'(0);
            5, 6: return comp_t'($signed($urandom_range(0, 32767)) - 16384);
            default: return comp_t'($urandom);
        endcase
    endfunction

    // Mostly near-unit axes so the rotation path is exercised, with some
    // arbitrary axes to drive the saturating intermediates.
    function automatic in_t rand_rotation();
        in_t t;
        int  pick;
        pick = $urandom_range(0, 9);
        t.axis_x = '0; t.axis_y = '0; t.axis_z = '0;
        if (pick < 4) begin
            case ($urandom_range(0, 5))
                0: t.axis_x = comp_t'(16384);
                1: t.axis_y = comp_t'(16384);
                2: t.axis_z = comp_t'(16384);
                3: t.axis_x = comp_t'(-16384);
                4: t.axis_y = comp_t'(-16384);
                default: t.axis_z = comp_t'(-16384);
            endcase
        end else if (pick < 6) begin
            // (1,1,1)/sqrt(3) style diagonal, random signs
            t.axis_x = comp_t'($urandom_range(0, 1) ? 9459 : -9459);
            t.axis_y = comp_t'($urandom_range(0, 1) ? 9459 : -9459);
            t.axis_z = comp_t'($urandom_range(0, 1) ? 9459 : -9459);
        end else begin
            t.axis_x = rand_comp();
            t.axis_y = rand_comp();
            t.axis_z = rand_comp();
        end
        t.vec_x = rand_comp();
        t.vec_y = rand_comp();
        t.vec_z = rand_comp();
        case ($urandom_range(0, 5))
            0: t.angle_deg = 16'($signed($urandom_range(0, 16)) * 1440 - 11520);
            1: t.angle_deg = $urandom_range(0, 1) ? 16'sd23040 : -16'sd23040;
            // out-of-range angles reduce modulo one turn
            2: t.angle_deg = 16'($urandom);
            default: t.angle_deg = 16'($signed($urandom_range(0, 46080)) - 23040);
        endcase
        return t;
    endfunction

    function automatic in_t make_rotation(int ax, int ay, int az, int vx, int vy,
                                          int vz, int ang);
        in_t t;
        t.axis_x = comp_t'(ax); t.axis_y = comp_t'(ay); t.axis_z = comp_t'(az);
        t.vec_x = comp_t'(vx);  t.vec_y = comp_t'(vy);  t.vec_z = comp_t'(vz);
        t.angle_deg = 16'(ang);
        return t;
    endfunction

    // ---------------------------------------------------------------------
    // Clock, reset, stimulus fill
    // ---------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        stimulus_done = 1'b0;
        error_count = 0;

        // Directed: quarter turns about each axis, zero and full turns,
        // extremes of every field, non-unit axes, angles beyond one turn.
        pending_rotations.push_back(make_rotation(16384, 0, 0, 0, 16384, 0, 5760));
        pending_rotations.push_back(make_rotation(0, 16384, 0, 0, 0, 16384, 5760));
        pending_rotations.push_back(make_rotation(0, 0, 16384, 16384, 0, 0, 5760));
        pending_rotations.push_back(make_rotation(0, 0, 16384, 16384, 0, 0, -5760));
        pending_rotations.push_back(make_rotation(0, 0, 16384, 16384, 0, 0, 11520));
        pending_rotations.push_back(make_rotation(0, 0, 16384, 16384, 0, 0, 17280));
        pending_rotations.push_back(make_rotation(0, 0, 16384, 16384, 9000, 0, 0));
        pending_rotations.push_back(make_rotation(0, 0, 16384, 16384, 9000, 0, 23040));
        pending_rotations.push_back(make_rotation(0, 0, 16384, 16384, 9000, 0, -23040));
        pending_rotations.push_back(make_rotation(9459, 9459, 9459, 16384, 0, 0, 7680));
        pending_rotations.push_back(make_rotation(9459, 9459, 9459, 0, 0, 16384, 1));
        pending_rotations.push_back(make_rotation(0, 0, 16384, 16384, 0, 0, 32767));
        pending_rotations.push_back(make_rotation(0, 0, 16384, 16384, 0, 0, -32768));
        pending_rotations.push_back(make_rotation(-32768, -32768, -32768,
                                                  32767, 32767, 32767, 2880));
        pending_rotations.push_back(make_rotation(32767, 32767, 32767,
                                                  -32768, -32768, -32768, 8640));
        pending_rotations.push_back(make_rotation(32767, -32768, 0,
                                                  -32768, 32767, 32767, -5760));
        pending_rotations.push_back(make_rotation(0, 0, 0, 32767, -32768, 1, 5760));
        pending_rotations.push_back(make_rotation(16384, 0, 0, 32767, 32767,
                                                  -32768, 11520));
        pending_rotations.push_back(make_rotation(-1, -1, -1, -1, -1, -1, -1));
        pending_rotations.push_back(make_rotation(24000, 0, 0, 0, 20000, 0, 4000));
        for (int i = 0; i < NUM_RANDOM; i++)
            pending_rotations.push_back(rand_rotation());

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ---------------------------------------------------------------------
    // Driver: bursts of random length separated by random gaps. Valid holds
    // with a stable payload until the transaction is taken.
    // ---------------------------------------------------------------------

    int  burst_left;
    int  gap_left;
    int  sent_count;
    bit  drain_done;
    // input handshake seen at the last rising edge
    bit  in_taken;

    initial
    begin
        in_valid = 1'b0;
        in_data = '0;
        burst_left = 0;
        gap_left = 0;
        sent_count = 0;
        drain_done = 1'b0;
        in_taken = 1'b0;
    end

    always @(negedge clk)
    begin
        bit  drive_valid;
        in_t drive_data;
        drive_valid = in_valid && !in_taken;
        drive_data = in_data;
        if (rst_n) begin
            if (in_taken)
                sent_count++;
            if (!drive_valid) begin
                if (!drain_done && sent_count >= 400) begin
                    // Once, midway, hold off until the pipeline has fully drained.
                    if (expected_rotations.size() == 0)
                        drain_done = 1'b1;
                end else if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_rotations.size() != 0) begin
                    drive_valid = 1'b1;
                    drive_data = pending_rotations.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    stimulus_done = 1'b1;
                end
            end
            in_valid <= drive_valid;
            in_data <= drive_data;
        end
    end

    // Receiver stall pattern: randomly chosen phases of always-ready and random
    // backpressure of varying density.
    int stall_phase_left;
    int stall_pct;

    initial
    begin
        out_ready = 1'b0;
        stall_phase_left = 0;
        stall_pct = 0;
    end

    always @(negedge clk)
    begin
        if (rst_n) begin
            if (stall_phase_left == 0) begin
                stall_phase_left = $urandom_range(20, 120);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            stall_phase_left--;
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Monitor and checker, sampled at the rising edge.
    // ---------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch @%0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        out_t want;
        in_taken = rst_n && in_valid && in_ready;
        if (rst_n) begin
            if (in_valid && in_ready)
                expected_rotations.push_back(rotate_vector(in_data));
            if (out_valid && out_ready) begin
                if (expected_rotations.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0);
                end else begin
                    want = expected_rotations.pop_front();
                    if (out_data.rot_x !== want.rot_x)
                        report_mismatch("rot_x", out_data.rot_x, want.rot_x);
                    if (out_data.rot_y !== want.rot_y)
                        report_mismatch("rot_y", out_data.rot_y, want.rot_y);
                    if (out_data.rot_z !== want.rot_z)
                        report_mismatch("rot_z", out_data.rot_z, want.rot_z);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // End of run
    // ---------------------------------------------------------------------

    initial
    begin
        wait (stimulus_done);
        wait (expected_rotations.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_rotations.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ~1120 transactions; ends the run as failed if they hang under stalls
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
